@@ src/daf_pkg.sv @@
// ----------------------------------------------------------------------------
// daf_pkg
// Shared widths, register codes, control types and saturation helpers of the
// admittance filter.
// ----------------------------------------------------------------------------
package daf_pkg;

  // Filter configuration
  localparam int AXES      = 4;
  localparam int COEF_FRAC = 14;
  localparam int B_FRAC    = 22;

  // Field and datapath widths
  localparam int REG_W   = 64;
  localparam int LANE_W  = 16;
  localparam int LANES   = REG_W / LANE_W;
  localparam int VAL_W   = 24;
  localparam int ERR_W   = VAL_W + 1;
  localparam int STATE_W = 32;
  localparam int PROD_W  = LANE_W + STATE_W;
  localparam int GPROD_W = LANE_W + ERR_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int IDX_W   = 3;

  // Item function code: measurement latch (the other code applies a reference)
  localparam logic FUNC_MEAS = 1'b0;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_COEF_PP = 3'd0,
    REG_COEF_PV = 3'd1,
    REG_COEF_VP = 3'd2,
    REG_COEF_VV = 3'd3,
    REG_GAIN_P  = 3'd4,
    REG_GAIN_V  = 3'd5
  } reg_idx_t;

  // Rounding offsets: half an LSB of the result
  localparam logic signed [ACC_W-1:0] RND_COEF = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] RND_GAIN = ACC_W'(1) <<< (B_FRAC - 1);

  localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]   ACC_MAX   = ACC_W'(STATE_MAX);
  localparam logic signed [ACC_W-1:0]   ACC_MIN   = ACC_W'(STATE_MIN);

  // Per-lane coefficient set
  typedef struct packed {
    logic signed [LANE_W-1:0] pp;
    logic signed [LANE_W-1:0] pv;
    logic signed [LANE_W-1:0] vp;
    logic signed [LANE_W-1:0] vv;
    logic signed [LANE_W-1:0] gp;
    logic signed [LANE_W-1:0] gv;
  } lane_coef_t;

  // Lane control from the sequencer
  typedef struct packed {
    logic load_meas;  // latch measured value
    logic step;       // form products from old state
    logic update;     // write new state
  } lane_ctl_t;

  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [ACC_W-1:0] x
  );
    if (x > ACC_MAX) begin
      return STATE_MAX;
    end else if (x < ACC_MIN) begin
      return STATE_MIN;
    end
    return x[STATE_W-1:0];
  endfunction

  function automatic logic signed [STATE_W-1:0] neg_state(
    input logic signed [STATE_W-1:0] x
  );
    if (x == STATE_MIN) begin
      return STATE_MAX;
    end
    return -x;
  endfunction

endpackage

@@ src/daf_in_if.sv @@
// ----------------------------------------------------------------------------
// daf_in_if
// Force channel: function code and one force or torque value per axis.
// ----------------------------------------------------------------------------
interface daf_in_if;
  import daf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [VAL_W-1:0] value_axis0;
  logic signed [VAL_W-1:0] value_axis1;
  logic signed [VAL_W-1:0] value_axis2;
  logic signed [VAL_W-1:0] value_axis3;

  modport source (
    output valid, func, value_axis0, value_axis1, value_axis2, value_axis3,
    input  ready
  );
  modport sink (
    input  valid, func, value_axis0, value_axis1, value_axis2, value_axis3,
    output ready
  );
endinterface

@@ src/daf_out_if.sv @@
// ----------------------------------------------------------------------------
// daf_out_if
// State channel: negated position and velocity of every axis.
// ----------------------------------------------------------------------------
interface daf_out_if;
  import daf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [STATE_W-1:0] pos_out0;
  logic signed [STATE_W-1:0] pos_out1;
  logic signed [STATE_W-1:0] pos_out2;
  logic signed [STATE_W-1:0] pos_out3;
  logic signed [STATE_W-1:0] vel_out0;
  logic signed [STATE_W-1:0] vel_out1;
  logic signed [STATE_W-1:0] vel_out2;
  logic signed [STATE_W-1:0] vel_out3;

  modport source (
    output valid, pos_out0, pos_out1, pos_out2, pos_out3,
           vel_out0, vel_out1, vel_out2, vel_out3,
    input  ready
  );
  modport sink (
    input  valid, pos_out0, pos_out1, pos_out2, pos_out3,
           vel_out0, vel_out1, vel_out2, vel_out3,
    output ready
  );
endinterface

@@ src/daf_lane.sv @@
// ----------------------------------------------------------------------------
// daf_lane
// One axis: latched measurement, position/velocity state, registered
// products and the rounded, saturated state update.
// ----------------------------------------------------------------------------
module daf_lane (
  input  logic                               clk,
  input  logic                               rst,
  input  daf_pkg::lane_ctl_t                 ctl,
  input  daf_pkg::lane_coef_t                coef,
  input  logic signed [daf_pkg::VAL_W-1:0]   value,
  output logic signed [daf_pkg::STATE_W-1:0] pos_neg,
  output logic signed [daf_pkg::STATE_W-1:0] vel_neg
);
  import daf_pkg::*;

  logic signed [VAL_W-1:0]   measured;
  logic signed [STATE_W-1:0] pos;
  logic signed [STATE_W-1:0] vel;
  logic signed [ERR_W-1:0]   err;

  logic signed [PROD_W-1:0]  p_pp;
  logic signed [PROD_W-1:0]  p_pv;
  logic signed [PROD_W-1:0]  p_vp;
  logic signed [PROD_W-1:0]  p_vv;
  logic signed [GPROD_W-1:0] p_gp;
  logic signed [GPROD_W-1:0] p_gv;

  logic signed [ACC_W-1:0]   acc_pos;
  logic signed [ACC_W-1:0]   acc_vel;
  logic signed [ACC_W-1:0]   frc_pos;
  logic signed [ACC_W-1:0]   frc_vel;
  logic signed [ACC_W-1:0]   pos_next;
  logic signed [ACC_W-1:0]   vel_next;

  // Error against the latched measurement
  assign err = ERR_W'(value) - ERR_W'(measured);

  // Negated old state for the result item
  assign pos_neg = neg_state(pos);
  assign vel_neg = neg_state(vel);

  // Latch measurement
  always_ff @(posedge clk) begin
    if (rst) begin
      measured <= '0;
    end else if (ctl.load_meas) begin
      measured <= value;
    end
  end

  // Register products of the old state and the error
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      p_pp <= PROD_W'(coef.pp) * PROD_W'(pos);
      p_pv <= PROD_W'(coef.pv) * PROD_W'(vel);
      p_vp <= PROD_W'(coef.vp) * PROD_W'(pos);
      p_vv <= PROD_W'(coef.vv) * PROD_W'(vel);
      p_gp <= GPROD_W'(coef.gp) * GPROD_W'(err);
      p_gv <= GPROD_W'(coef.gv) * GPROD_W'(err);
    end
  end

  // Round both terms half up, then sum
  assign acc_pos  = (ACC_W'(p_pp) + ACC_W'(p_pv) + RND_COEF) >>> COEF_FRAC;
  assign acc_vel  = (ACC_W'(p_vp) + ACC_W'(p_vv) + RND_COEF) >>> COEF_FRAC;
  assign frc_pos  = (ACC_W'(p_gp) + RND_GAIN) >>> B_FRAC;
  assign frc_vel  = (ACC_W'(p_gv) + RND_GAIN) >>> B_FRAC;
  assign pos_next = acc_pos + frc_pos;
  assign vel_next = acc_vel + frc_vel;

  // Write saturated state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      vel <= '0;
    end else if (ctl.update) begin
      pos <= sat_state(pos_next);
      vel <= sat_state(vel_next);
    end
  end

endmodule

@@ src/daf_merge.sv @@
// ----------------------------------------------------------------------------
// daf_merge
// Gathers the lanes' negated states into one result item and holds it in
// the output register until the sink takes it.
// ----------------------------------------------------------------------------
module daf_merge (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic signed [daf_pkg::STATE_W-1:0] pos_neg [daf_pkg::LANES],
  input  logic signed [daf_pkg::STATE_W-1:0] vel_neg [daf_pkg::LANES],
  output logic                               free,
  daf_out_if.source                          state_ch
);
  import daf_pkg::*;

  logic                      out_valid;
  logic signed [STATE_W-1:0] pos_r [LANES];
  logic signed [STATE_W-1:0] vel_r [LANES];

  assign free = !out_valid || state_ch.ready;

  // Hold valid until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (state_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture lanes; axes beyond the configured count read zero
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < LANES; i++) begin
        pos_r[i] <= (i < AXES) ? pos_neg[i] : '0;
        vel_r[i] <= (i < AXES) ? vel_neg[i] : '0;
      end
    end
  end

  assign state_ch.valid    = out_valid;
  assign state_ch.pos_out0 = pos_r[0];
  assign state_ch.pos_out1 = pos_r[1];
  assign state_ch.pos_out2 = pos_r[2];
  assign state_ch.pos_out3 = pos_r[3];
  assign state_ch.vel_out0 = vel_r[0];
  assign state_ch.vel_out1 = vel_r[1];
  assign state_ch.vel_out2 = vel_r[2];
  assign state_ch.vel_out3 = vel_r[3];

endmodule

@@ src/discrete_admittance_filter.sv @@
// ----------------------------------------------------------------------------
// discrete_admittance_filter
// Four-axis mass-spring-damper admittance filter. A measurement item (func 0)
// latches the four measured forces. A reference item (func 1) arriving after
// a measurement returns the negated position and velocity of every axis and
// steps the state through the state loop of each lane: it first registers
// the coefficient and gain products, then rounds, sums, saturates and writes
// the new state. A reference item before any measurement is dropped. An
// accepted item waits in the input register until issued, and the result is
// held in the output register; the two let the next item be taken while a
// result waits. The coefficient registers are to be written on the cfg port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module discrete_admittance_filter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [daf_pkg::IDX_W-1:0]        cfg_index,
  input  logic [daf_pkg::REG_W-1:0]        cfg_data,
  daf_in_if.sink                           force_ch,
  daf_out_if.source                        state_ch
);
  import daf_pkg::*;

  // Configuration registers
  logic [REG_W-1:0] coef_pos_pos;
  logic [REG_W-1:0] coef_pos_vel;
  logic [REG_W-1:0] coef_vel_pos;
  logic [REG_W-1:0] coef_vel_vel;
  logic [REG_W-1:0] gain_force_pos;
  logic [REG_W-1:0] gain_force_vel;

  // Input item register and sequencing
  logic                    itm_valid;
  logic                    itm_func;
  logic signed [VAL_W-1:0] itm_value [LANES];
  logic                    busy;
  logic                    seen;
  logic                    out_free;
  logic                    is_meas;
  logic                    issue;
  logic                    is_step;
  lane_ctl_t               ctl;

  logic signed [STATE_W-1:0] pos_neg [LANES];
  logic signed [STATE_W-1:0] vel_neg [LANES];

  // Decode register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_pos_pos   <= '0;
      coef_pos_vel   <= '0;
      coef_vel_pos   <= '0;
      coef_vel_vel   <= '0;
      gain_force_pos <= '0;
      gain_force_vel <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_PP: coef_pos_pos   <= cfg_data;
        REG_COEF_PV: coef_pos_vel   <= cfg_data;
        REG_COEF_VP: coef_vel_pos   <= cfg_data;
        REG_COEF_VV: coef_vel_vel   <= cfg_data;
        REG_GAIN_P:  gain_force_pos <= cfg_data;
        REG_GAIN_V:  gain_force_vel <= cfg_data;
        default: ;
      endcase
    end
  end

  // Issue the held item when the lanes and the output register allow it
  assign is_meas        = (itm_func == FUNC_MEAS);
  assign issue          = itm_valid && !busy && (is_meas || !seen || out_free);
  assign is_step        = issue && !is_meas && seen;
  assign force_ch.ready = !itm_valid || issue;

  assign ctl.load_meas = issue && is_meas;
  assign ctl.step      = is_step;
  assign ctl.update    = busy;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      itm_valid <= 1'b0;
    end else if (force_ch.ready) begin
      itm_valid <= force_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (force_ch.valid && force_ch.ready) begin
      itm_func     <= force_ch.func;
      itm_value[0] <= force_ch.value_axis0;
      itm_value[1] <= force_ch.value_axis1;
      itm_value[2] <= force_ch.value_axis2;
      itm_value[3] <= force_ch.value_axis3;
    end
  end

  // Track the update cycle and the first measurement
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      seen <= 1'b0;
    end else begin
      busy <= is_step;
      if (ctl.load_meas) begin
        seen <= 1'b1;
      end
    end
  end

  // Axis lanes; lanes beyond the configured count stay frozen
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    lane_coef_t coef;
    lane_ctl_t  lane_ctl;

    assign coef.pp  = coef_pos_pos[LANE_W*i +: LANE_W];
    assign coef.pv  = coef_pos_vel[LANE_W*i +: LANE_W];
    assign coef.vp  = coef_vel_pos[LANE_W*i +: LANE_W];
    assign coef.vv  = coef_vel_vel[LANE_W*i +: LANE_W];
    assign coef.gp  = gain_force_pos[LANE_W*i +: LANE_W];
    assign coef.gv  = gain_force_vel[LANE_W*i +: LANE_W];
    assign lane_ctl = (i < AXES) ? ctl : '0;

    daf_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (lane_ctl),
      .coef    (coef),
      .value   (itm_value[i]),
      .pos_neg (pos_neg[i]),
      .vel_neg (vel_neg[i])
    );
  end

  // Merge lanes into the result item
  daf_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (is_step),
    .pos_neg  (pos_neg),
    .vel_neg  (vel_neg),
    .free     (out_free),
    .state_ch (state_ch)
  );

endmodule
